[hw/rtl/greedy_box_suppression_assert.svh]
// Assertion macros for the box suppression block.
// Used by the port checker; no other dependencies.
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// Same-cycle implication, off during reset.
`define GBS_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, off during reset.
`define GBS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/gbs_pkg.sv]
// Shared constants and types for the box suppression block.
// No dependencies.
package gbs_pkg;

  localparam int DIM_W   = 15;
  localparam int AREA_W  = 30;
  localparam int THR_W   = 9;
  localparam int IDX_W   = 12;
  localparam int ADDR_W  = 2;
  localparam int IOU_LAT = 5;

  localparam logic [THR_W-1:0]  THR_RESET = 9'd179;
  localparam logic [IDX_W-1:0]  INDEX_MAX = 12'd4095;
  localparam logic [ADDR_W-1:0] ADDR_THR  = 2'd0;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

[hw/rtl/gbs_cell.sv]
// One link of the kept-box ring: holds one packed box.
// Depends on gbs_pkg for the control struct.
module gbs_cell #(
  parameter int W = 92
) (
  input  logic              clk,
  input  gbs_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]      ring_in,
  input  logic [W-1:0]      load_in,
  output logic [W-1:0]      q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_in;
    end else if (ctl.shift) begin
      q <= ring_in;
    end
  end

endmodule

[hw/rtl/gbs_iou.sv]
// Pipelined overlap test of the candidate against one kept box per cycle.
// Depends on gbs_pkg for field widths.
module gbs_iou #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue,
  input  logic signed [COORD_BITS-1:0]  cand_left,
  input  logic signed [COORD_BITS-1:0]  cand_top,
  input  logic [gbs_pkg::DIM_W-1:0]     cand_w,
  input  logic [gbs_pkg::DIM_W-1:0]     cand_h,
  input  logic [gbs_pkg::AREA_W-1:0]    cand_area,
  input  logic [gbs_pkg::THR_W-1:0]     thr,
  input  logic [2*COORD_BITS+59:0]      entry,
  output logic                          over
);

  localparam int EW  = (COORD_BITS > 16 ? COORD_BITS : 16) + 1;
  localparam int DW  = gbs_pkg::DIM_W;
  localparam int AW  = gbs_pkg::AREA_W;
  localparam int UW  = AW + 1;
  localparam int LW  = AW + 8;
  localparam int RW  = UW + gbs_pkg::THR_W;
  localparam int CB  = COORD_BITS;

  function automatic logic [DW-1:0] overlap(input logic signed [CB-1:0] a0,
                                            input logic [DW-1:0] al,
                                            input logic signed [CB-1:0] b0,
                                            input logic [DW-1:0] bl);
    logic signed [EW-1:0] a_lo, a_hi, b_lo, b_hi, lo, hi, diff;
    a_lo = EW'(a0);
    b_lo = EW'(b0);
    a_hi = a_lo + EW'($signed({1'b0, al}));
    b_hi = b_lo + EW'($signed({1'b0, bl}));
    lo   = (a_lo > b_lo) ? a_lo : b_lo;
    hi   = (a_hi < b_hi) ? a_hi : b_hi;
    diff = hi - lo;
    overlap = (hi > lo) ? diff[DW-1:0] : '0;
  endfunction

  logic signed [CB-1:0] e_left, e_top;
  logic [DW-1:0]        e_w, e_h;
  logic [AW-1:0]        e_area;

  assign e_left = entry[CB-1:0];
  assign e_top  = entry[2*CB-1:CB];
  assign e_w    = entry[2*CB+DW-1:2*CB];
  assign e_h    = entry[2*CB+2*DW-1:2*CB+DW];
  assign e_area = entry[2*CB+2*DW+AW-1:2*CB+2*DW];

  logic          s1_v, s2_v, s3_v, s4_v;
  logic [DW-1:0] s1_iw, s1_ih;
  logic [AW-1:0] s1_karea, s2_karea, s2_inter, s3_inter;
  logic [UW-1:0] s3_uni;
  logic [LW-1:0] s4_lhs;
  logic [RW-1:0] s4_rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      over <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      over <= s4_v && (RW'(s4_lhs) > s4_rhs);
    end
  end

  always_ff @(posedge clk) begin
    s1_iw    <= overlap(cand_left, cand_w, e_left, e_w);
    s1_ih    <= overlap(cand_top, cand_h, e_top, e_h);
    s1_karea <= e_area;
    s2_inter <= s1_iw * s1_ih;
    s2_karea <= s1_karea;
    s3_inter <= s2_inter;
    s3_uni   <= UW'(cand_area) + UW'(s2_karea) - UW'(s2_inter);
    s4_lhs   <= {s3_inter, 8'b0};
    s4_rhs   <= RW'(thr) * RW'(s3_uni);
  end

endmodule

[hw/rtl/greedy_box_suppression.sv]
// Greedy IoU box suppression, top level: ring of kept-box cells, one
// shared overlap pipeline, sequencer and config register.
// Depends on gbs_pkg, gbs_cell and gbs_iou.
//
// Usage:
//   Candidate boxes enter on the s_ stream, sorted by descending score.
//   s_tuser set on a beat starts a new frame: the kept list and the box
//   index restart before that box is judged. One result beat per box
//   leaves on the m_ stream: keep, store_full and the box index.
//   The threshold register (1/256 units, reset 179) sits at address 0;
//   write it only while the block is idle; no logic enforces this.
//   Each box is judged by rotating the ring of MAX_KEPT cells past the
//   overlap pipeline, one kept box per cycle, then draining that 5-stage
//   pipeline, before the result beat is loaded. A new box is taken only
//   once the previous box's result is in the output register.
//   Reset clears the kept count, the box index, the output beat and
//   restores the threshold; no memory sweep is needed.
//   A stalled receiver holds the result beat; the next box is still
//   accepted and judged, and waits for the output register to free.
module greedy_box_suppression #(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbs_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // box_left, box_top, box_width, box_height, zero pad
  input  logic [((2*COORD_BITS+30+7)/8)*8-1:0] s_tdata,
  // first_of_frame
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // box_index, zero pad
  output logic [15:0]                       m_tdata,
  // keep, store_full
  output logic [1:0]                        m_tuser
);

  localparam int CB = COORD_BITS;
  localparam int DW = gbs_pkg::DIM_W;
  localparam int BW = 2*CB + 60;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int SW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int LW = $clog2(gbs_pkg::IOU_LAT);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  state_t                     state;
  logic [SW-1:0]              step;
  logic [LW-1:0]              dcnt;
  logic [CW-1:0]              kept_count;
  logic [gbs_pkg::IDX_W-1:0]  box_counter;
  logic [gbs_pkg::IDX_W-1:0]  cur_idx;
  logic [gbs_pkg::IDX_W-1:0]  idx_next;
  logic                       suppress;
  logic [gbs_pkg::THR_W-1:0]  thr;

  logic signed [CB-1:0]         cand_left, cand_top;
  logic [DW-1:0]                cand_w, cand_h;
  logic [gbs_pkg::AREA_W-1:0]   cand_area;

  logic                         accept, out_free, full, over, issue;
  logic [BW-1:0]                cell_q [MAX_KEPT];
  logic [BW-1:0]                load_word;
  gbs_pkg::cell_ctl_t           cell_ctl [MAX_KEPT];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign full      = (kept_count == CW'(MAX_KEPT));
  assign issue     = (state == S_RUN) && (CW'(step) < kept_count);
  assign idx_next  = s_tuser ? '0 : box_counter;
  assign load_word = {cand_area, cand_h, cand_w, cand_top, cand_left};

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr == gbs_pkg::ADDR_THR) ? 32'(thr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gbs_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == gbs_pkg::ADDR_THR) begin
      thr <= pwdata[gbs_pkg::THR_W-1:0];
    end
  end

  // Candidate hold
  always_ff @(posedge clk) begin
    if (accept) begin
      cand_left <= s_tdata[CB-1:0];
      cand_top  <= s_tdata[2*CB-1:CB];
      cand_w    <= s_tdata[2*CB+DW-1:2*CB];
      cand_h    <= s_tdata[2*CB+2*DW-1:2*CB+DW];
    end
    cand_area <= cand_w * cand_h;
  end

  // Sequencer and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      dcnt        <= '0;
      kept_count  <= '0;
      box_counter <= '0;
      suppress    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if (over && state != S_IDLE) begin
        suppress <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              kept_count <= '0;
            end
            cur_idx     <= idx_next;
            box_counter <= (idx_next == gbs_pkg::INDEX_MAX) ? idx_next
                                                             : idx_next + 1'b1;
            suppress    <= 1'b0;
            step        <= '0;
            state       <= S_RUN;
          end
        end
        S_RUN: begin
          step <= step + 1'b1;
          if (step == SW'(MAX_KEPT - 1)) begin
            dcnt  <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == LW'(gbs_pkg::IOU_LAT - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 16'(cur_idx);
            m_tuser  <= {!suppress && full, !suppress};
            if (!suppress && !full) begin
              kept_count <= kept_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Ring of kept boxes
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    assign cell_ctl[i].shift = (state == S_RUN);
    assign cell_ctl[i].load  = (state == S_DONE) && out_free && !suppress &&
                               (kept_count == CW'(i));
    gbs_cell #(.W(BW)) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .ring_in (cell_q[(i + 1) % MAX_KEPT]),
      .load_in (load_word),
      .q       (cell_q[i])
    );
  end

  gbs_iou #(.COORD_BITS(COORD_BITS)) u_iou (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .cand_left (cand_left),
    .cand_top  (cand_top),
    .cand_w    (cand_w),
    .cand_h    (cand_h),
    .cand_area (cand_area),
    .thr       (thr),
    .entry     (cell_q[0]),
    .over      (over)
  );

endmodule

[hw/rtl/gbs_checker.sv]
// Port-level checker for the box suppression block, bound to the top level.
// Depends on greedy_box_suppression_assert.svh.
`include "greedy_box_suppression_assert.svh"

module gbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `GBS_ASSERT(a_full_implies_keep, m_tvalid && m_tuser[1], m_tuser[0], "store_full without keep")
  `GBS_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `GBS_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat dropped")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (.*);

[test/tb_top.sv]
// Self-checking bench for greedy_box_suppression: boxes stream in, keep/full/index verdicts
// are predicted in-bench and compared beat by beat. Depends on gbs_pkg and the block's RTL.
module tb_top;

  localparam int KEPT_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DW = gbs_pkg::DIM_W;
  localparam int TW = gbs_pkg::THR_W;

  typedef struct packed {
    logic                      first;
    logic [15:0]               left;
    logic [15:0]               top;
    logic [DW-1:0]             w;
    logic [DW-1:0]             h;
  } box_t;

  typedef struct packed {
    logic                      keep;
    logic                      full;
    logic [gbs_pkg::IDX_W-1:0] index;
  } verdict_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [gbs_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [63:0]                s_tdata;
  logic                       s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [15:0]                m_tdata;
  logic [1:0]                 m_tuser;

  greedy_box_suppression DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  box_t       box_backlog[$];
  verdict_t   expected_verdicts[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         src_idle_pct = 10;
  int         sink_idle_pct = 70;
  logic       s_beat = 1'b0;

  // in-bench copy of the suppression state
  logic [TW-1:0]             iou_thr = gbs_pkg::THR_RESET;
  longint                    kept_l[KEPT_DEPTH];
  longint                    kept_t[KEPT_DEPTH];
  longint                    kept_w[KEPT_DEPTH];
  longint                    kept_h[KEPT_DEPTH];
  longint                    kept_a[KEPT_DEPTH];
  int                        kept_total = 0;
  logic [gbs_pkg::IDX_W-1:0] frame_index = '0;

  function automatic void add_box(box_t b);
    box_backlog.insert(box_backlog.size(), b);
  endfunction

  function automatic longint span_overlap(longint a0, longint alen, longint b0, longint blen);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic verdict_t judge_box(box_t b);
    verdict_t v;
    longint   l;
    longint   t;
    longint   w;
    longint   h;
    longint   area;
    longint   inter;
    longint   uni;
    l = longint'($signed(b.left));
    t = longint'($signed(b.top));
    w = longint'(b.w);
    h = longint'(b.h);
    area = w * h;
    if (b.first) begin
      kept_total = 0;
      frame_index = '0;
    end
    v.index = frame_index;
    if (frame_index != gbs_pkg::INDEX_MAX) frame_index = frame_index + 1'b1;
    v.keep = 1'b1;
    v.full = 1'b0;
    for (int k = 0; k < kept_total; k++) begin
      inter = span_overlap(l, w, kept_l[k], kept_w[k]) * span_overlap(t, h, kept_t[k], kept_h[k]);
      uni = area + kept_a[k] - inter;
      if (inter * 256 > longint'(iou_thr) * uni) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (kept_total < KEPT_DEPTH) begin
        kept_l[kept_total] = l;
        kept_t[kept_total] = t;
        kept_w[kept_total] = w;
        kept_h[kept_total] = h;
        kept_a[kept_total] = area;
        kept_total++;
      end else begin
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  // stream driver
  always @(negedge clk) begin : feed
    box_t nb;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_beat) begin
      if (box_backlog.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        nb = box_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nb.first;
        s_tdata <= {2'b00, nb.h, nb.w, nb.top, nb.left};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // monitor: predict on accepted boxes, check accepted verdicts
  always @(posedge clk) begin : watch
    box_t     b;
    verdict_t exp_v;
    if (rst) begin
      s_beat = 1'b0;
    end else begin
      s_beat = s_tvalid && s_tready;
      if (s_beat) begin
        b.first = s_tuser;
        b.left = s_tdata[15:0];
        b.top = s_tdata[31:16];
        b.w = s_tdata[46:32];
        b.h = s_tdata[61:47];
        expected_verdicts.insert(expected_verdicts.size(), judge_box(b));
      end
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result beat: index %0d", m_tdata[gbs_pkg::IDX_W-1:0]);
          error_count++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (m_tuser[0] !== exp_v.keep) begin
            $error("keep: expected %0d, got %0d", exp_v.keep, m_tuser[0]);
            error_count++;
          end
          if (m_tuser[1] !== exp_v.full) begin
            $error("store_full: expected %0d, got %0d", exp_v.full, m_tuser[1]);
            error_count++;
          end
          if (m_tdata[gbs_pkg::IDX_W-1:0] !== exp_v.index) begin
            $error("box_index: expected %0d, got %0d", exp_v.index,
                   m_tdata[gbs_pkg::IDX_W-1:0]);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[greedy_box_suppression] ERROR");
      $finish;
    end
  end

  function automatic box_t mk(logic first, int left, int top, int w, int h);
    box_t b;
    b.first = first;
    b.left = 16'(left);
    b.top = 16'(top);
    b.w = DW'(w);
    b.h = DW'(h);
    return b;
  endfunction

  task automatic settle();
    while (box_backlog.size() > 0 || s_tvalid || expected_verdicts.size() > 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [TW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= gbs_pkg::ADDR_THR;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    iou_thr = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      $error("threshold: expected %0d, got %0d", value, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic box_t grid_box(logic first, int slot);
    return mk(first, -8192 + (slot % 16) * 1024, -8192 + (slot / 16) * 1024,
              $urandom_range(1000, 16), $urandom_range(1000, 16));
  endfunction

  function automatic box_t jitter_box(box_t base);
    box_t j;
    int   nw;
    int   nh;
    j = base;
    j.first = 1'b0;
    j.left = base.left + 16'($urandom_range(128, 0)) - 16'd64;
    j.top = base.top + 16'($urandom_range(128, 0)) - 16'd64;
    nw = int'(base.w) + int'($urandom_range(64, 0)) - 32;
    nh = int'(base.h) + int'($urandom_range(64, 0)) - 32;
    j.w = DW'((nw < 0) ? 0 : (nw > 32767) ? 32767 : nw);
    j.h = DW'((nh < 0) ? 0 : (nh > 32767) ? 32767 : nh);
    return j;
  endfunction

  task automatic queue_frame(int len, bit grid_heavy);
    box_t frame_boxes[$];
    box_t b;
    int   cells;
    int   roll;
    cells = 0;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99, 0);
      if (grid_heavy && i < 100 && cells < 256 && roll < 80) begin
        b = grid_box(i == 0, cells);
        cells++;
      end else if (roll < 30 && cells < 256) begin
        b = grid_box(i == 0, cells);
        cells++;
      end else if (roll < 65 && frame_boxes.size() > 0) begin
        b = jitter_box(frame_boxes[$urandom_range(frame_boxes.size() - 1, 0)]);
      end else if (roll < 85) begin
        b = mk(i == 0, $urandom, $urandom, $urandom, $urandom);
      end else begin
        b = mk(i == 0, int'($urandom_range(64, 0)) - 32, int'($urandom_range(64, 0)) - 32,
               $urandom_range(3, 0), $urandom_range(3, 0));
      end
      b.first = (i == 0);
      frame_boxes.insert(frame_boxes.size(), b);
      add_box(b);
    end
  endtask

  task automatic queue_segment(int n_items);
    int queued;
    int len;
    bit heavy;
    queued = 0;
    while (queued < n_items) begin
      heavy = ($urandom_range(3, 0) == 0);
      len = heavy ? $urandom_range(110, 65) : $urandom_range(60, 1);
      queue_frame(len, heavy);
      queued += len;
    end
  endtask

  initial begin : stimulus
    logic [TW-1:0] seg_thr[6];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset threshold: extremes, duplicates, partial overlap, zero-area boxes, frame restart
    add_box(mk(1, -32768, -32768, 32767, 32767));
    add_box(mk(0, -32768, -32768, 32767, 32767));
    add_box(mk(0, 32767, 32767, 32767, 32767));
    add_box(mk(0, 0, 0, 0, 0));
    add_box(mk(0, 0, 0, 0, 0));
    add_box(mk(0, 100, 100, 160, 160));
    add_box(mk(0, 110, 100, 160, 160));
    add_box(mk(0, 148, 100, 160, 160));
    add_box(mk(1, 100, 100, 160, 160));
    settle();
    write_threshold(9'd256);
    add_box(mk(1, 0, 0, 320, 320));
    add_box(mk(0, 0, 0, 320, 320));
    settle();
    write_threshold(9'd0);
    add_box(mk(1, 0, 0, 32, 32));
    add_box(mk(0, 32, 0, 32, 32));
    add_box(mk(0, 31, 31, 32, 32));
    add_box(mk(0, 0, 0, 0, 0));
    settle();
    write_threshold(9'd511);
    add_box(mk(1, -16, -16, 32767, 32767));
    add_box(mk(0, -16, -16, 32767, 32767));
    settle();

    seg_thr[0] = 9'd128;
    seg_thr[1] = 9'd0;
    seg_thr[2] = 9'd511;
    seg_thr[3] = TW'($urandom_range(255, 1));
    seg_thr[4] = 9'd256;
    seg_thr[5] = gbs_pkg::THR_RESET;
    for (int s = 0; s < 6; s++) begin
      if (s == 2) begin
        src_idle_pct = 70;
        sink_idle_pct = 10;
      end else if (s == 4) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_threshold(seg_thr[s]);
      queue_segment(300);
      settle();
    end

    repeat (2 * (KEPT_DEPTH + gbs_pkg::IOU_LAT + 2)) @(posedge clk);
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("[greedy_box_suppression] OK");
    end else begin
      $display("[greedy_box_suppression] ERROR");
    end
    $finish;
  end

endmodule

[greedy_box_suppression.f]
+incdir+hw/rtl
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_cell.sv
hw/rtl/gbs_iou.sv
hw/rtl/greedy_box_suppression.sv
hw/rtl/gbs_checker.sv
test/tb_top.sv
